### rtl/pwcd_pkg.sv
// pwcd_pkg: shared types and constants for the pulse width command decoder
// no dependencies; imported by pwcd_track, pwcd_classify, the top level and the testbench
`default_nettype none

package pwcd_pkg;

  typedef enum logic [2:0] {
    CMD_OFF     = 3'd0,
    CMD_REVERSE = 3'd1,
    CMD_LEFT    = 3'd2,
    CMD_RIGHT   = 3'd3,
    CMD_FORWARD = 3'd4
  } cmd_t;

  localparam logic [4:0] PAT_OFF     = 5'h00;
  localparam logic [4:0] PAT_REVERSE = 5'h09;
  localparam logic [4:0] PAT_LEFT    = 5'h0A;
  localparam logic [4:0] PAT_RIGHT   = 5'h11;
  localparam logic [4:0] PAT_FORWARD = 5'h12;

  // band bounds, open below and closed above
  localparam logic [7:0] FWD_LO = 8'd90;
  localparam logic [7:0] FWD_HI = 8'd104;
  localparam logic [7:0] RGT_LO = 8'd79;
  localparam logic [7:0] RGT_HI = 8'd87;
  localparam logic [7:0] LFT_LO = 8'd60;
  localparam logic [7:0] LFT_HI = 8'd68;
  localparam logic [7:0] REV_LO = 8'd28;
  localparam logic [7:0] REV_HI = 8'd36;

  localparam int unsigned MARGIN_W   = 4;
  localparam int unsigned HELD_OUT_W = 8;
  localparam int unsigned WIDE_W     = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd4;
  localparam logic                REG_MARGIN   = 1'b0;

  typedef struct packed {
    cmd_t       command;
    logic [4:0] pattern;
  } decode_t;

  function automatic logic band_hit(input logic [WIDE_W-1:0] v,
                                    input logic [7:0] lo,
                                    input logic [7:0] hi);
    logic [WIDE_W-1:0] lo_w;
    logic [WIDE_W-1:0] hi_w;
    lo_w = WIDE_W'(lo);
    hi_w = WIDE_W'(hi);
    return (v > lo_w) && (v <= hi_w);
  endfunction

endpackage

`default_nettype wire

### rtl/pwcd_track.sv
// pwcd_track: edge detect, saturating tick counter and held width with hysteresis
// depends on pwcd_pkg
`default_nettype none

module pwcd_track import pwcd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    line_level,
  input  wire                    tick,
  input  wire [MARGIN_W-1:0]     margin,
  output logic [COUNT_WIDTH-1:0] held_cur,
  output logic [COUNT_WIDTH-1:0] held_nxt
);

  localparam int unsigned CW1 = COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] HELD_RESET = COUNT_WIDTH'(4);

  logic                   prev_r, prev_nxt;
  logic                   meas_r, meas_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] held_r;
  logic                   rise, fall;
  logic [CW1-1:0]         cnt_w, held_w, margin_w;
  logic                   in_window;

  always_comb begin
    rise     = line_level & ~prev_r;
    fall     = ~line_level & prev_r;
    prev_nxt = line_level;
    meas_nxt = meas_r;
    cnt_nxt  = cnt_r;
    if (rise) begin
      cnt_nxt  = '0;
      meas_nxt = 1'b1;
    end else if (fall) begin
      meas_nxt = 1'b0;
    end else if (meas_r && tick && (cnt_r != CNT_TOP)) begin
      cnt_nxt = cnt_r + COUNT_WIDTH'(1);
    end
  end

  // window (held - margin, held + margin] without wrap
  always_comb begin
    cnt_w     = CW1'(cnt_nxt);
    held_w    = CW1'(held_r);
    margin_w  = CW1'(margin);
    in_window = ((cnt_w + margin_w) > held_w) && (cnt_w <= (held_w + margin_w));
    held_nxt  = held_r;
    if (!line_level && !in_window) begin
      held_nxt = cnt_nxt;
    end
  end

  assign held_cur = held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      meas_r <= 1'b0;
      cnt_r  <= '0;
      held_r <= HELD_RESET;
    end else if (en) begin
      prev_r <= prev_nxt;
      meas_r <= meas_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pwcd_classify.sv
// pwcd_classify: sorts a held width into a command and drive pattern
// depends on pwcd_pkg
`default_nettype none

module pwcd_classify import pwcd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire [COUNT_WIDTH-1:0] held,
  output decode_t               dec,
  output logic [HELD_OUT_W-1:0] held_shown
);

  logic [WIDE_W-1:0] held_w;

  always_comb begin
    held_w = WIDE_W'(held);
    if (band_hit(held_w, FWD_LO, FWD_HI)) begin
      dec = '{command: CMD_FORWARD, pattern: PAT_FORWARD};
    end else if (band_hit(held_w, RGT_LO, RGT_HI)) begin
      dec = '{command: CMD_RIGHT, pattern: PAT_RIGHT};
    end else if (band_hit(held_w, LFT_LO, LFT_HI)) begin
      dec = '{command: CMD_LEFT, pattern: PAT_LEFT};
    end else if (band_hit(held_w, REV_LO, REV_HI)) begin
      dec = '{command: CMD_REVERSE, pattern: PAT_REVERSE};
    end else begin
      dec = '{command: CMD_OFF, pattern: PAT_OFF};
    end
    held_shown = (held_w > WIDE_W'(255)) ? {HELD_OUT_W{1'b1}} : held_w[HELD_OUT_W-1:0];
  end

endmodule

`default_nettype wire

### rtl/pulse_width_command_decoder.sv
// pulse_width_command_decoder: top level, input word register, result register, apb margin
// input register, then result register; one word per cycle unless a waiting result stalls
// input register plus result register, so a word is taken while a result waits
// reset (synchronous, rst_n low): counter idle at 0, held width 4, margin 4, both stages empty
// depends on pwcd_pkg, pwcd_track and pwcd_classify
`default_nettype none

module pulse_width_command_decoder import pwcd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_line_level,
  input  wire                   in_tick,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [2:0]            out_command,
  output logic [4:0]            out_drive_pattern,
  output logic [HELD_OUT_W-1:0] out_held_value,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [ADDR_W-1:0]     paddr,
  input  wire  [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic                   in_valid_r;
  logic                   level_r;
  logic                   tick_r;
  logic                   out_valid_r;
  cmd_t                   command_r;
  logic [4:0]             pattern_r;
  logic [HELD_OUT_W-1:0]  held_shown_r;
  logic [MARGIN_W-1:0]    margin_r;
  logic                   advance;
  logic                   cfg_wr;
  logic [COUNT_WIDTH-1:0] held_cur;
  logic [COUNT_WIDTH-1:0] held_nxt;
  decode_t                dec;
  logic [HELD_OUT_W-1:0]  held_shown;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MARGIN);
  assign prdata   = (paddr[2] == REG_MARGIN) ? DATA_W'(margin_r) : '0;

  pwcd_track #(.COUNT_WIDTH(COUNT_WIDTH)) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .line_level (level_r),
    .tick       (tick_r),
    .margin     (margin_r),
    .held_cur   (held_cur),
    .held_nxt   (held_nxt)
  );

  pwcd_classify #(.COUNT_WIDTH(COUNT_WIDTH)) u_classify (
    .held       (held_nxt),
    .dec        (dec),
    .held_shown (held_shown)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_wr) begin
      margin_r <= pwdata[MARGIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      level_r <= in_line_level;
      tick_r  <= in_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command_r    <= dec.command;
      pattern_r    <= dec.pattern;
      held_shown_r <= held_shown;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command       = command_r;
  assign out_drive_pattern = pattern_r;
  assign out_held_value    = held_shown_r;

  a_held_while_high: assert property (@(posedge clk) disable iff (!rst_n)
    advance && level_r |-> held_nxt == held_cur)
    else $error("held width changed while line high");

  a_off_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((command_r == CMD_OFF) == (pattern_r == PAT_OFF)))
    else $error("command and drive pattern disagree");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(level_r) && $stable(tick_r))
    else $error("stalled input word lost");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result not registered after advance");

endmodule

`default_nettype wire

### test/tb_pulse_width_command_decoder.sv
// tb_pulse_width_command_decoder: self-checking bench that drives receiver line samples and
// margin writes, predicts the command, drive pattern and held width of every word, and checks them
// depends on pwcd_pkg and pulse_width_command_decoder
module tb_pulse_width_command_decoder import pwcd_pkg::*; ();

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [7:0] HELD_RESET = 8'd4;
  localparam logic [ADDR_W-1:0] MARGIN_ADDR = ADDR_W'(4 * int'(REG_MARGIN));
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

  typedef struct packed {
    cmd_t       command;
    logic [4:0] pattern;
    logic [7:0] held;
  } drive_word_t;

  typedef struct packed {
    logic        level;
    logic        tick;
    logic        typed;
    drive_word_t want;
  } sample_row_t;

  // only the first word after reset is typed in: count 0 falls outside (0,8], held drops to 0
  localparam sample_row_t DIRECTED [25] = '{
    '{1'b0, 1'b0, 1'b1, '{CMD_OFF, PAT_OFF, 8'd0}},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_line_level;
  logic                  in_tick;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            out_command;
  logic [4:0]            out_drive_pattern;
  logic [HELD_OUT_W-1:0] out_held_value;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  logic                  seen_level;
  logic                  running;
  logic [7:0]            pulse_count;
  logic [7:0]            held_ticks;
  logic [MARGIN_W-1:0]   margin_ticks;

  drive_word_t           decoded_q[$];
  int                    mismatches = 0;
  int                    words_sent = 0;
  bit                    calm = 1'b0;
  bit                    hold_off = 1'b0;

  pulse_width_command_decoder #(.COUNT_WIDTH(8)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_line_level(in_line_level), .in_tick(in_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_command(out_command), .out_drive_pattern(out_drive_pattern),
    .out_held_value(out_held_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch: %s got %0d want %0d", what, got, want);
  endtask

  function automatic drive_word_t decode_sample(input logic level, input logic tick);
    drive_word_t r;
    int lo;
    int hi;
    if (level && !seen_level) begin
      pulse_count = 8'd0;
      running = 1'b1;
    end else if (!level && seen_level) begin
      running = 1'b0;
    end else if (running && tick && pulse_count != 8'hFF) begin
      pulse_count = pulse_count + 8'd1;
    end
    seen_level = level;
    if (!level) begin
      lo = int'(held_ticks) - int'(margin_ticks);
      hi = int'(held_ticks) + int'(margin_ticks);
      if (!(int'(pulse_count) > lo && int'(pulse_count) <= hi)) held_ticks = pulse_count;
    end
    if (held_ticks > FWD_LO && held_ticks <= FWD_HI) begin
      r.command = CMD_FORWARD;
      r.pattern = PAT_FORWARD;
    end else if (held_ticks > RGT_LO && held_ticks <= RGT_HI) begin
      r.command = CMD_RIGHT;
      r.pattern = PAT_RIGHT;
    end else if (held_ticks > LFT_LO && held_ticks <= LFT_HI) begin
      r.command = CMD_LEFT;
      r.pattern = PAT_LEFT;
    end else if (held_ticks > REV_LO && held_ticks <= REV_HI) begin
      r.command = CMD_REVERSE;
      r.pattern = PAT_REVERSE;
    end else begin
      r.command = CMD_OFF;
      r.pattern = PAT_OFF;
    end
    r.held = held_ticks;
    return r;
  endfunction

  task automatic send_word(input logic level, input logic tick,
                           input logic typed = 1'b0, input drive_word_t want = '0);
    drive_word_t next;
    in_valid <= 1'b1;
    in_line_level <= level;
    in_tick <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    next = decode_sample(level, tick);
    decoded_q.push_back(typed ? want : next);
    words_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic int pick_width();
    int d;
    int w;
    case ($urandom_range(0, 9))
      0, 1: return int'($urandom_range(0, 12));
      2: return int'($urandom_range(0, 120));
      3, 4: begin
        d = int'($urandom_range(0, int'(margin_ticks) + 1));
        w = $urandom_range(0, 1) ? int'(held_ticks) + d : int'(held_ticks) - d;
        if (w < 0) w = 0;
        if (w > 255) w = 255;
        return w;
      end
      5: return int'($urandom_range(int'(REV_LO), int'(REV_HI) + 1));
      6: return int'($urandom_range(int'(LFT_LO), int'(LFT_HI) + 1));
      7: return int'($urandom_range(int'(RGT_LO), int'(RGT_HI) + 1));
      default: return int'($urandom_range(int'(FWD_LO), int'(FWD_HI) + 1));
    endcase
  endfunction

  task automatic send_pulse(input int width);
    int got;
    logic tk;
    repeat ($urandom_range(1, 3)) send_word(1'b0, 1'($urandom_range(0, 1)));
    send_word(1'b1, 1'($urandom_range(0, 1)));
    got = 0;
    while (got < width) begin
      tk = ($urandom_range(0, 7) != 0);
      send_word(1'b1, tk);
      if (tk) got++;
    end
    send_word(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_samples(input int budget);
    int stop;
    stop = words_sent + budget;
    while (words_sent < stop) begin
      if ($urandom_range(0, 9) < 2) begin
        // line noise and broken pulses
        repeat ($urandom_range(1, 8)) begin
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        send_pulse(pick_width());
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == MARGIN_ADDR) margin_ticks = data[MARGIN_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_margin_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MARGIN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(margin_ticks)) begin
      flag_mismatch("margin readback", int'(prdata), int'(margin_ticks));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_side
    out_ready <= 1'b0;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_out
    drive_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("word with none pending", int'(out_held_value), 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_command !== want.command) begin
          flag_mismatch("command", int'(out_command), int'(want.command));
        end
        if (out_drive_pattern !== want.pattern) begin
          flag_mismatch("drive_pattern", int'(out_drive_pattern), int'(want.pattern));
        end
        if (out_held_value !== want.held) begin
          flag_mismatch("held_value", int'(out_held_value), int'(want.held));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_line_level <= 1'b0;
    in_tick <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    seen_level = 1'b0;
    running = 1'b0;
    pulse_count = 8'd0;
    held_ticks = HELD_RESET;
    margin_ticks = MARGIN_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_margin_readback();

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].level, DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);
    end
    run_samples(50);

    drain();
    apb_write(MARGIN_ADDR, '0);
    check_margin_readback();
    run_samples(60);

    // widest margin, counter driven into saturation while the result side holds off
    drain();
    apb_write(MARGIN_ADDR, '1);
    check_margin_readback();
    hold_off = 1'b1;
    send_pulse(270);
    run_samples(40);

    drain();
    apb_write(UNUSED_ADDR, $urandom);
    apb_write(MARGIN_ADDR, {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'($urandom_range(1, 14))});
    check_margin_readback();
    run_samples(40);
    calm = 1'b1;
    run_samples(50);

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
